// File: design/hashed_timing_wheel_defines.svh
// ----------------------------------------------------------------------------
// Hashed timing wheel assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef HASHED_TIMING_WHEEL_DEFINES_SVH
`define HASHED_TIMING_WHEEL_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define HTW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define HTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/htw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel package
// Field widths, register codes, result kinds, FSM states and channel payloads.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int TASK_ID_W = 16;
  localparam int DELAY_W   = 24;
  localparam int KIND_W    = 2;
  localparam int CFG_W     = 10;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CFG_W-1:0] TICK_MS_RST = 10'd10;
  localparam logic [CFG_W-1:0] IMM_MS_RST  = 10'd10;

  typedef enum logic {
    REG_TICK_MS = 1'b0,
    REG_IMM_MS  = 1'b1
  } htw_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED   = 2'd0,
    KIND_DROPPED = 2'd1,
    KIND_FIRED   = 2'd2,
    KIND_IDLE    = 2'd3
  } htw_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_T,
    ST_DIV_N,
    ST_AREAD,
    ST_CNT,
    ST_WALK,
    ST_TEND
  } htw_state_e;

  typedef struct packed {
    logic [CFG_W-1:0] tick_ms;
    logic [CFG_W-1:0] immediate_limit_ms;
  } htw_cfg_t;

  typedef struct packed {
    logic                 command;
    logic [TASK_ID_W-1:0] task_id;
    logic [DELAY_W-1:0]   delay_ms;
  } htw_in_t;

  typedef struct packed {
    logic [KIND_W-1:0]    result_kind;
    logic [TASK_ID_W-1:0] fired_id;
    logic                 last;
  } htw_out_t;

endpackage

// File: design/htw_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface htw_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// File: design/htw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel generic RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/htw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module htw_div #(
  parameter int WIDTH = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [WIDTH-1:0] rem_q;
  logic [WIDTH-1:0] quo_q;
  logic [WIDTH-1:0] dvs_q;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo_q <= {quo_q[WIDTH-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: design/htw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel configuration registers
// APB-style register file for tick length and immediate limit.
// ----------------------------------------------------------------------------
module htw_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [htw_pkg::PADDR_W-1:0]  paddr,
  input  logic [htw_pkg::PDATA_W-1:0]  pwdata,
  output logic [htw_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output htw_pkg::htw_cfg_t            cfg_o
);

  import htw_pkg::*;

  logic [CFG_W-1:0] tick_q;
  logic [CFG_W-1:0] imm_q;
  htw_reg_e         reg_sel;
  logic             wr_en;

  assign reg_sel = htw_reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= TICK_MS_RST;
      imm_q  <= IMM_MS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TICK_MS: tick_q <= pwdata[CFG_W-1:0];
        REG_IMM_MS:  imm_q  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TICK_MS: prdata = PDATA_W'(tick_q);
      REG_IMM_MS:  prdata = PDATA_W'(imm_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.tick_ms            = tick_q;
  assign cfg_o.immediate_limit_ms = imm_q;

endmodule

// File: design/hashed_timing_wheel.sv
// Add: a short delay goes to the slot after the current one; a long one is
//   divided by the tick length, then a reciprocal multiply gives rotations and slot.
// Tick: entries of the current slot are walked one entry a cycle through the entry
//   memory read port, while the output does not stall. One item is in work at a time.
// Reset: current slot 0, both registers 10, slot counts read as zero through
//   per-slot valid bits; no clearing pass, entry memory is not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel
// Ring of slots held in an entry memory and a count memory, walked per tick.
// ----------------------------------------------------------------------------
module hashed_timing_wheel #(
  parameter int NUM_SLOTS  = 16,
  parameter int SLOT_DEPTH = 16,
  parameter int ID_WIDTH   = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  htw_stream_if.sink                  in_i,
  htw_stream_if.source                out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [htw_pkg::PADDR_W-1:0] paddr,
  input  logic [htw_pkg::PDATA_W-1:0] pwdata,
  output logic [htw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  import htw_pkg::*;

  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int IDX_W     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int CNT_W     = $clog2(SLOT_DEPTH + 1);
  localparam int ROT_W     = DELAY_W - ($clog2(NUM_SLOTS + 1) - 1);
  localparam int ENT_W     = ID_WIDTH + ROT_W;
  localparam int ENT_DEPTH = NUM_SLOTS * (2 ** IDX_W);
  localparam int ENT_AW    = $clog2(ENT_DEPTH);
  localparam int RCP_SH    = DELAY_W + SLOT_W;
  localparam int PROD_W    = 2 * DELAY_W + 1;

  localparam logic [DELAY_W:0] RCP =
    (DELAY_W + 1)'(((64'd1 << RCP_SH) + 64'(NUM_SLOTS - 1)) / 64'(NUM_SLOTS));
  localparam logic [SLOT_W-1:0] SLOTS_LO = SLOT_W'(NUM_SLOTS);

  htw_cfg_t cfg;

  htw_state_e state_q, state_d;

  logic                 cmd_q;
  logic [TASK_ID_W-1:0] tid_q;
  logic [DELAY_W-1:0]   dly_q;
  logic [SLOT_W-1:0]    cur_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [ROT_W-1:0]     rot_q;
  logic [CNT_W-1:0]     n_q;
  logic [CNT_W-1:0]     i_q;
  logic [CNT_W-1:0]     kept_q;
  logic                 pend_vld_q;
  logic [ID_WIDTH-1:0]  pend_id_q;
  logic                 cnt_vld_q;
  logic [NUM_SLOTS-1:0] vld_q;
  logic                 out_vld_q;
  htw_kind_e            out_kind_q;
  logic [ID_WIDTH-1:0]  out_id_q;
  logic                 out_last_q;

  logic                 div_start;
  logic [DELAY_W-1:0]   div_dividend;
  logic [DELAY_W-1:0]   div_divisor;
  logic                 div_done;
  logic [DELAY_W-1:0]   div_quot;

  logic                 cnt_rd_en;
  logic                 cnt_wr_en;
  logic [CNT_W-1:0]     cnt_wr_data;
  logic [CNT_W-1:0]     cnt_rdata;
  logic                 ent_rd_en;
  logic [ENT_AW-1:0]    ent_rd_addr;
  logic                 ent_wr_en;
  logic [ENT_AW-1:0]    ent_wr_addr;
  logic [ENT_W-1:0]     ent_wr_data;
  logic [ENT_W-1:0]     ent_rdata;

  logic                 in_ready;
  logic                 in_xfer;
  logic                 emit;
  htw_kind_e            emit_kind;
  logic [ID_WIDTH-1:0]  emit_id;
  logic                 emit_last;

  logic                 out_free;
  logic [ID_WIDTH-1:0]  tid_m;
  logic [CNT_W-1:0]     cnt_val;
  logic                 cnt_full;
  logic                 imm_hit;
  logic [DELAY_W-1:0]   tick_eff;
  logic [SLOT_W-1:0]    cur_nxt;
  logic [PROD_W-1:0]    rcp_prod;
  logic [SLOT_W-1:0]    rot_lo_n;
  logic [SLOT_W-1:0]    hash_rem;
  logic [SLOT_W:0]      slot_sum;
  logic [SLOT_W-1:0]    long_slot;
  logic [ROT_W-1:0]     walk_rot;
  logic [ID_WIDTH-1:0]  walk_id;
  logic                 walk_fire;
  logic                 walk_go;
  logic [CNT_W-1:0]     i_nxt;
  logic                 walk_end;

  htw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  htw_div #(
    .WIDTH (DELAY_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  htw_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_SLOTS)
  ) u_cnt_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cnt_wr_en),
    .wr_addr_i (slot_q),
    .wr_data_i (cnt_wr_data),
    .rd_en_i   (cnt_rd_en),
    .rd_addr_i (slot_q),
    .rd_data_o (cnt_rdata)
  );

  htw_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENT_DEPTH)
  ) u_ent_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ent_wr_en),
    .wr_addr_i (ent_wr_addr),
    .wr_data_i (ent_wr_data),
    .rd_en_i   (ent_rd_en),
    .rd_addr_i (ent_rd_addr),
    .rd_data_o (ent_rdata)
  );

  assign in_xfer   = in_i.valid && in_ready;
  assign out_free  = !out_vld_q || out_o.ready;
  assign tid_m     = ID_WIDTH'(tid_q);
  assign cnt_val   = cnt_vld_q ? cnt_rdata : '0;
  assign cnt_full  = (cnt_val >= CNT_W'(SLOT_DEPTH));
  assign imm_hit   = (dly_q <= DELAY_W'(cfg.immediate_limit_ms));
  assign tick_eff  = (cfg.tick_ms == '0) ? DELAY_W'(1) : DELAY_W'(cfg.tick_ms);
  assign cur_nxt   = (cur_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : cur_q + 1'b1;
  assign rcp_prod  = PROD_W'(div_quot) * PROD_W'(RCP);
  assign rot_lo_n  = rot_q[SLOT_W-1:0] * SLOTS_LO;
  assign hash_rem  = div_quot[SLOT_W-1:0] - rot_lo_n;
  assign slot_sum  = {1'b0, hash_rem} + {1'b0, cur_q};
  assign long_slot = (slot_sum >= (SLOT_W + 1)'(NUM_SLOTS))
                     ? SLOT_W'(slot_sum - (SLOT_W + 1)'(NUM_SLOTS))
                     : slot_sum[SLOT_W-1:0];
  assign walk_rot  = ent_rdata[ROT_W-1:0];
  assign walk_id   = ent_rdata[ENT_W-1 -: ID_WIDTH];
  assign walk_fire = (walk_rot == '0);
  assign walk_go   = !walk_fire || !pend_vld_q || out_free;
  assign i_nxt     = i_q + 1'b1;
  assign walk_end  = (i_nxt == n_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_PREP;
      end
      ST_PREP: begin
        if (cmd_q || imm_hit) state_d = ST_AREAD;
        else                  state_d = ST_DIV_T;
      end
      ST_DIV_T: begin
        if (div_done) state_d = ST_DIV_N;
      end
      ST_DIV_N: state_d = ST_AREAD;
      ST_AREAD: state_d = ST_CNT;
      ST_CNT: begin
        if (!cmd_q) begin
          if (out_free) state_d = ST_IDLE;
        end else if (cnt_val == '0) begin
          state_d = ST_TEND;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_go && walk_end) state_d = ST_TEND;
      end
      ST_TEND: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = dly_q;
    div_divisor  = tick_eff;
    cnt_rd_en    = 1'b0;
    cnt_wr_en    = 1'b0;
    cnt_wr_data  = kept_q;
    ent_rd_en    = 1'b0;
    ent_rd_addr  = {slot_q, i_nxt[IDX_W-1:0]};
    ent_wr_en    = 1'b0;
    ent_wr_addr  = {slot_q, kept_q[IDX_W-1:0]};
    ent_wr_data  = {walk_id, walk_rot - 1'b1};
    emit         = 1'b0;
    emit_kind    = KIND_IDLE;
    emit_id      = '0;
    emit_last    = 1'b1;
    case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_PREP: begin
        if (!cmd_q && !imm_hit) div_start = 1'b1;
      end
      ST_DIV_T: ;
      ST_DIV_N: ;
      ST_AREAD: cnt_rd_en = 1'b1;
      ST_CNT: begin
        if (!cmd_q) begin
          if (out_free) begin
            emit    = 1'b1;
            emit_id = tid_m;
            if (cnt_full) begin
              emit_kind = KIND_DROPPED;
            end else begin
              emit_kind   = KIND_ADDED;
              ent_wr_en   = 1'b1;
              ent_wr_addr = {slot_q, cnt_val[IDX_W-1:0]};
              ent_wr_data = {tid_m, rot_q};
              cnt_wr_en   = 1'b1;
              cnt_wr_data = cnt_val + 1'b1;
            end
          end
        end else if (cnt_val != '0) begin
          ent_rd_en   = 1'b1;
          ent_rd_addr = {slot_q, IDX_W'(0)};
        end
      end
      ST_WALK: begin
        if (!walk_fire) ent_wr_en = 1'b1;
        if (walk_fire && pend_vld_q && out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_FIRED;
          emit_id   = pend_id_q;
          emit_last = 1'b0;
        end
        if (walk_go && !walk_end) ent_rd_en = 1'b1;
      end
      ST_TEND: begin
        if (out_free) begin
          emit      = 1'b1;
          cnt_wr_en = 1'b1;
          if (pend_vld_q) begin
            emit_kind = KIND_FIRED;
            emit_id   = pend_id_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_q      <= '0;
      vld_q      <= '0;
      cnt_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PREP && cmd_q) cur_q <= cur_nxt;
      if (state_q == ST_AREAD) cnt_vld_q <= vld_q[slot_q];
      if (cnt_wr_en) vld_q[slot_q] <= 1'b1;
      if (state_q == ST_CNT) begin
        pend_vld_q <= 1'b0;
      end else if (state_q == ST_WALK && walk_go && walk_fire) begin
        pend_vld_q <= 1'b1;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= in_i.data.command;
      tid_q <= in_i.data.task_id;
      dly_q <= in_i.data.delay_ms;
    end
    if (state_q == ST_PREP) begin
      slot_q <= cmd_q ? cur_q : cur_nxt;
      rot_q  <= '0;
    end
    if (state_q == ST_DIV_T && div_done) begin
      rot_q <= rcp_prod[RCP_SH +: ROT_W];
    end
    if (state_q == ST_DIV_N) begin
      slot_q <= long_slot;
    end
    if (state_q == ST_CNT) begin
      n_q    <= cnt_val;
      i_q    <= '0;
      kept_q <= '0;
    end
    if (state_q == ST_WALK && walk_go) begin
      i_q <= i_nxt;
      if (walk_fire) begin
        pend_id_q <= walk_id;
      end else begin
        kept_q <= kept_q + 1'b1;
      end
    end
    if (emit) begin
      out_kind_q <= emit_kind;
      out_id_q   <= emit_id;
      out_last_q <= emit_last;
    end
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_vld_q;
  assign out_o.data.result_kind = out_kind_q;
  assign out_o.data.fired_id   = TASK_ID_W'(out_id_q);
  assign out_o.data.last       = out_last_q;

endmodule

// File: design/htw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel port checker
// Assertions on the stream ports of the timing wheel, bound to the top level.
// ----------------------------------------------------------------------------
`include "hashed_timing_wheel_defines.svh"

module htw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [htw_pkg::KIND_W-1:0]    out_kind_i,
  input logic [htw_pkg::TASK_ID_W-1:0] out_id_i,
  input logic                          out_last_i
);

  import htw_pkg::*;

  `HTW_ASSERT_NOW(a_idle_tick_form, out_valid_i && (out_kind_i == KIND_IDLE), (out_id_i == '0) && out_last_i, "empty tick result must carry id 0 and last")
  `HTW_ASSERT_NOW(a_add_single, out_valid_i && ((out_kind_i == KIND_ADDED) || (out_kind_i == KIND_DROPPED)), out_last_i, "add result must be the last of its item")
  `HTW_ASSERT_NOW(a_more_only_fired, out_valid_i && !out_last_i, out_kind_i == KIND_FIRED, "only fired results may be followed by more")
  `HTW_ASSERT_NEXT(a_one_in_work, in_valid_i && in_ready_i, !in_ready_i, "input taken while an item is still in work")
  `HTW_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_id_i) && $stable(out_last_i), "stalled result changed")

endmodule

bind hashed_timing_wheel htw_checker u_htw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.data.result_kind),
  .out_id_i    (out_o.data.fired_id),
  .out_last_i  (out_o.data.last)
);

// File: tb/sv/htw_wheel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel checker
// Watches the command, result and register channels, keeps a model of the
// wheel, and compares every result transfer with the oldest predicted one.
// ----------------------------------------------------------------------------
module htw_wheel_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  logic                        cmd_ready_i,
  input  htw_pkg::htw_in_t            cmd_data_i,
  input  logic                        res_valid_i,
  input  logic                        res_ready_i,
  input  htw_pkg::htw_out_t           res_data_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [htw_pkg::PADDR_W-1:0] paddr_i,
  input  logic [htw_pkg::PDATA_W-1:0] pwdata_i,
  output int                          pending_o,
  output int                          errors_o
);

  import htw_pkg::*;

  localparam int SLOTS = 16;
  localparam int DEPTH = 16;

  logic [CFG_W-1:0]     tick_ms_q;
  logic [CFG_W-1:0]     imm_ms_q;
  logic [3:0]           wheel_now;
  logic [TASK_ID_W-1:0] slot_id  [SLOTS][DEPTH];
  logic [19:0]          slot_rot [SLOTS][DEPTH];
  int                   slot_fill[SLOTS];
  htw_out_t             results_due[$];

  task automatic report_mismatch(string what);
    $display("ERROR %0t: %s", $time, what);
    errors_o++;
  endtask

  function automatic void wheel_outcome(htw_in_t item);
    logic [3:0]       slot;
    logic [3:0]       old;
    logic [19:0]      rot;
    logic [23:0]      units;
    logic [CFG_W-1:0] unit_ms;
    htw_out_t         res;
    int               kept;
    int               fired;
    int               i;
    if (item.command == 1'b0) begin
      if (item.delay_ms <= 24'(imm_ms_q)) begin
        slot = wheel_now + 4'd1;
        rot  = '0;
      end else begin
        unit_ms = (tick_ms_q == '0) ? CFG_W'(1) : tick_ms_q;
        units   = item.delay_ms / 24'(unit_ms);
        slot    = wheel_now + units[3:0];
        rot     = units[23:4];
      end
      res.fired_id = item.task_id;
      res.last     = 1'b1;
      if (slot_fill[slot] >= DEPTH) begin
        res.result_kind = KIND_DROPPED;
      end else begin
        slot_id[slot][slot_fill[slot]]  = item.task_id;
        slot_rot[slot][slot_fill[slot]] = rot;
        slot_fill[slot]++;
        res.result_kind = KIND_ADDED;
      end
      results_due.insert(results_due.size(), res);
    end else begin
      old       = wheel_now;
      wheel_now = wheel_now + 4'd1;
      kept      = 0;
      fired     = 0;
      for (i = 0; i < slot_fill[old]; i++) begin
        if (slot_rot[old][i] == '0) begin
          res.result_kind = KIND_FIRED;
          res.fired_id    = slot_id[old][i];
          res.last        = 1'b0;
          results_due.insert(results_due.size(), res);
          fired++;
        end else begin
          slot_id[old][kept]  = slot_id[old][i];
          slot_rot[old][kept] = slot_rot[old][i] - 20'd1;
          kept++;
        end
      end
      slot_fill[old] = kept;
      if (fired == 0) begin
        res.result_kind = KIND_IDLE;
        res.fired_id    = '0;
        res.last        = 1'b1;
        results_due.insert(results_due.size(), res);
      end else begin
        res      = results_due[results_due.size() - 1];
        res.last = 1'b1;
        results_due[results_due.size() - 1] = res;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    htw_out_t want;
    if (!rst_ni) begin
      tick_ms_q = TICK_MS_RST;
      imm_ms_q  = IMM_MS_RST;
      wheel_now = '0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_fill[s] = 0;
      end
      results_due.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[PADDR_W-1:2] == REG_TICK_MS) begin
          tick_ms_q = pwdata_i[CFG_W-1:0];
        end else if (paddr_i[PADDR_W-1:2] == REG_IMM_MS) begin
          imm_ms_q = pwdata_i[CFG_W-1:0];
        end
      end
      if (cmd_valid_i && cmd_ready_i) begin
        wheel_outcome(cmd_data_i);
      end
      if (res_valid_i && res_ready_i) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d id %h last %b",
                                    res_data_i.result_kind, res_data_i.fired_id,
                                    res_data_i.last));
        end else begin
          want = results_due[0];
          results_due.delete(0);
          if (res_data_i.result_kind !== want.result_kind ||
              res_data_i.fired_id !== want.fired_id ||
              res_data_i.last !== want.last) begin
            report_mismatch($sformatf(
              "result kind %0d/%0d id %h/%h last %b/%b (got/want)",
              res_data_i.result_kind, want.result_kind, res_data_i.fired_id,
              want.fired_id, res_data_i.last, want.last));
          end
        end
      end
      pending_o <= results_due.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel testbench
// Drives add and tick commands and register writes through several settings
// and idling patterns; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module testbench;

  import htw_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int N_PHASES    = 5;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 pending;
  int                 errors;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int cur_tick;
  int cur_imm;

  int phase_tick [N_PHASES] = '{1, 1000, 0, 7, 3};
  int phase_imm  [N_PHASES] = '{0, 1000, 5, 1023, 20};
  int phase_gap  [N_PHASES] = '{0, 49, 0, 13, 0};
  int phase_stall[N_PHASES] = '{0, 0, 49, 13, 0};
  int phase_items[N_PHASES] = '{90, 90, 90, 90, 60};

  htw_stream_if #(.payload_t(htw_in_t))  cmd_ch ();
  htw_stream_if #(.payload_t(htw_out_t)) res_ch ();

  hashed_timing_wheel dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_ch),
    .out_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  htw_wheel_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_ch.valid),
    .cmd_ready_i (cmd_ch.ready),
    .cmd_data_i  (cmd_ch.data),
    .res_valid_i (res_ch.valid),
    .res_ready_i (res_ch.ready),
    .res_data_i  (res_ch.data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : receiver
    int stall_left;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
        res_ch.ready <= 1'b0;
        repeat (stall_left - 1) @(posedge clk_i);
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [TASK_ID_W-1:0] id,
                           input logic [DELAY_W-1:0] delay);
    htw_in_t item;
    item.command  = cmd;
    item.task_id  = id;
    item.delay_ms = delay;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= item;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
  endtask

  function automatic logic [DELAY_W-1:0] pick_delay();
    int unit_ms;
    unit_ms = (cur_tick == 0) ? 1 : cur_tick;
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5: return DELAY_W'($urandom_range(cur_imm));
      6:                return DELAY_W'(cur_imm + 1);
      7:                return DELAY_W'($urandom());
      8:                return 24'hFFFFFF - DELAY_W'($urandom_range(255));
      default:          return DELAY_W'(unit_ms * $urandom_range(47) +
                                        $urandom_range(unit_ms - 1));
    endcase
  endfunction

  task automatic send_random();
    if ($urandom_range(99) < 35) begin
      send_item(1'b1, TASK_ID_W'($urandom()), DELAY_W'($urandom()));
    end else begin
      send_item(1'b0, TASK_ID_W'($urandom()), pick_delay());
    end
  endtask

  // hold the command channel quiet until every predicted result is back
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input htw_reg_e idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {22'($urandom()), value[CFG_W-1:0]};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    cur_tick       = 10;
    cur_imm        = 10;
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // immediate, boundary, longest and one-rotation adds, then walk them
    send_item(1'b0, 16'hFFFF, 24'd0);
    send_item(1'b0, 16'h0000, 24'd10);
    send_item(1'b0, 16'hA5A5, 24'hFFFFFF);
    send_item(1'b0, 16'h5A5A, 24'd160);
    send_item(1'b1, 16'h0000, 24'd0);
    send_item(1'b1, 16'hFFFF, 24'hFFFFFF);
    // fill one slot past its depth, then fire it whole
    for (int k = 0; k < 17; k++) begin
      send_item(1'b0, TASK_ID_W'($urandom()), DELAY_W'(k % 11));
    end
    send_item(1'b1, 16'h1234, 24'd0);
    send_item(1'b1, 16'h4321, 24'd0);

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      write_reg(REG_TICK_MS, phase_tick[p]);
      write_reg(REG_IMM_MS, phase_imm[p]);
      cur_tick       = phase_tick[p];
      cur_imm        = phase_imm[p];
      send_idle_pct  = phase_gap[p];
      recv_stall_pct = phase_stall[p];
      if (p == N_PHASES - 1) begin
        hold_request = 600;
        repeat (40) send_random();
        drain_results();
      end
      repeat (phase_items[p]) send_random();
    end

    drain_results();
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
